### rtl/isc_pkg.sv
// isc_pkg: shared widths, reset values, register indexes, status codes and
// the control struct for the IMU sample stuck check.
// No dependencies; every other file of the block imports it.
package isc_pkg;

   localparam int WORD_W  = 16;   // raw and published sensor word
   localparam int LANES   = 6;    // accel x/y/z, gyro x/y/z
   localparam int AXES    = 3;    // magnetometer axes
   localparam int CNT_W   = 8;    // identical-read count, mag tick, limits
   localparam int FAIL_W  = 16;   // failure counters
   localparam int CSR_W   = 16;   // widest configuration register
   localparam int CSR_A_W = 3;    // configuration register index

   localparam logic [CNT_W-1:0] STUCK_LIMIT_RESET = CNT_W'(5);
   localparam logic [CNT_W-1:0] MAG_DIVIDER_RESET = CNT_W'(10);
   localparam logic [CNT_W-1:0] MAG_TICK_RESET    = CNT_W'(10);

   // first gyro lane; lanes below it carry accel words
   localparam int GYRO_LANE0 = 3;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_GYRO_OFS_X = 3'd0,
      CSR_GYRO_OFS_Y = 3'd1,
      CSR_GYRO_OFS_Z = 3'd2,
      CSR_STUCK_LIM  = 3'd3,
      CSR_MAG_DIV    = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_PUB       = 3'd0,
      ST_MAG_OK    = 3'd1,
      ST_MAG_FAIL  = 3'd2,
      ST_READ_FAIL = 3'd3,
      ST_STUCK     = 3'd4
   } status_type;

   // decisions of the merge stage for the current word
   typedef struct packed {
      logic commit;     // good, not stuck: lanes keep and publish
      logic mag_load;   // mag fetch due and good: capture mag words
   } ctl_type;

endpackage

### rtl/isc_lane.sv
// isc_lane: one sensor axis lane. Holds the last kept raw word and the
// published word, compares the incoming raw word and subtracts the offset.
// Depends on isc_pkg.
module isc_lane
   import isc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              commit,
   input  logic [WORD_W-1:0] raw_word,
   input  logic [WORD_W-1:0] offset,
   output logic              match,
   output logic [WORD_W-1:0] pub_word
);

   logic [WORD_W-1:0] last_raw_ff, last_raw_in;
   logic [WORD_W-1:0] pub_ff, pub_in;

   // compare against the last kept word
   assign match = (raw_word == last_raw_ff);

   // keep raw word and publish corrected word on commit, wrap at 16 bits
   always_comb begin
      last_raw_in = last_raw_ff;
      pub_in      = pub_ff;
      if (commit) begin
         last_raw_in = raw_word;
         pub_in      = raw_word - offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= '0;
         pub_ff      <= '0;
      end else begin
         last_raw_ff <= last_raw_in;
         pub_ff      <= pub_in;
      end
   end

   assign pub_word = pub_ff;

endmodule

### rtl/isc_merge.sv
// isc_merge: merges the lane match flags into the stuck decision, runs the
// identical-read count, the mag fetch tick, status and failure counters.
// Depends on isc_pkg.
module isc_merge
   import isc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              read_ok,
   input  logic              mag_ok,
   input  logic [LANES-1:0]  lane_match,
   input  logic [CNT_W-1:0]  stuck_limit,
   input  logic [CNT_W-1:0]  mag_divider,
   output ctl_type           ctl,
   output status_type        status,
   output logic [FAIL_W-1:0] read_fail_count,
   output logic [FAIL_W-1:0] mag_fail_count
);

   logic [CNT_W-1:0]  same_count_ff, same_count_in;
   logic [CNT_W-1:0]  mag_tick_ff, mag_tick_in;
   status_type        status_ff, status_in;
   logic [FAIL_W-1:0] read_fail_ff, read_fail_in;
   logic [FAIL_W-1:0] mag_fail_ff, mag_fail_in;

   logic              all_match;
   logic [CNT_W-1:0]  same_next;
   logic [CNT_W-1:0]  tick_next;
   logic              stuck;
   logic              due;

   assign all_match = &lane_match;

   // identical-read count as it stands after this word, saturating
   always_comb begin
      if (!all_match) begin
         same_next = '0;
      end else if (same_count_ff == '1) begin
         same_next = same_count_ff;
      end else begin
         same_next = same_count_ff + CNT_W'(1);
      end
   end

   assign stuck = (same_next >= stuck_limit);

   // mag tick advance, saturating
   assign tick_next = (mag_tick_ff == '1) ? mag_tick_ff : mag_tick_ff + CNT_W'(1);
   assign due       = (tick_next >= mag_divider);

   assign ctl.commit   = accept && read_ok && !stuck;
   assign ctl.mag_load = ctl.commit && due && mag_ok;

   // next state and status of the merged decision
   always_comb begin
      same_count_in = same_count_ff;
      mag_tick_in   = mag_tick_ff;
      status_in     = status_ff;
      read_fail_in  = read_fail_ff;
      mag_fail_in   = mag_fail_ff;
      if (accept) begin
         if (!read_ok) begin
            status_in    = ST_READ_FAIL;
            read_fail_in = (read_fail_ff == '1) ? read_fail_ff : read_fail_ff + FAIL_W'(1);
         end else begin
            same_count_in = same_next;
            if (stuck) begin
               status_in    = ST_STUCK;
               read_fail_in = (read_fail_ff == '1) ? read_fail_ff
                                                   : read_fail_ff + FAIL_W'(1);
            end else if (due) begin
               mag_tick_in = '0;
               if (mag_ok) begin
                  status_in = ST_MAG_OK;
               end else begin
                  status_in   = ST_MAG_FAIL;
                  mag_fail_in = (mag_fail_ff == '1) ? mag_fail_ff
                                                    : mag_fail_ff + FAIL_W'(1);
               end
            end else begin
               mag_tick_in = tick_next;
               status_in   = ST_PUB;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         same_count_ff <= '0;
         mag_tick_ff   <= MAG_TICK_RESET;
         status_ff     <= ST_PUB;
         read_fail_ff  <= '0;
         mag_fail_ff   <= '0;
      end else begin
         same_count_ff <= same_count_in;
         mag_tick_ff   <= mag_tick_in;
         status_ff     <= status_in;
         read_fail_ff  <= read_fail_in;
         mag_fail_ff   <= mag_fail_in;
      end
   end

   assign status          = status_ff;
   assign read_fail_count = read_fail_ff;
   assign mag_fail_count  = mag_fail_ff;

endmodule

### rtl/imu_sample_stuck_check.sv
// imu_sample_stuck_check: top level. Six axis lanes, the merge stage, the
// magnetometer hold, configuration registers and the result handshake.
// Depends on isc_pkg, isc_lane and isc_merge.
//
//   channel | ports      | direction | moves
//   --------+------------+-----------+---------------------------------------
//   request | req_*      | in        | one sensor sample word
//   result  | rsp_*      | out       | one published word per sample
//   config  | csr_*      | in        | register writes, no read-back
//
// One sample a cycle while the request side is not stalled: each accepted word
// is checked by the six lanes and the merge stage in the cycle it is taken, and
// its result appears in the result register on the next cycle. The request side
// stalls only while a result waits under a result stall. Synchronous reset sets
// the magnetometer tick to 10 so the first good sample fetches, sets the stuck
// limit and magnetometer divider to 5 and 10, and clears all other state.
module imu_sample_stuck_check
   import isc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_read_ok,
   input  logic signed [WORD_W-1:0]  req_accel_x,
   input  logic signed [WORD_W-1:0]  req_accel_y,
   input  logic signed [WORD_W-1:0]  req_accel_z,
   input  logic signed [WORD_W-1:0]  req_gyro_x,
   input  logic signed [WORD_W-1:0]  req_gyro_y,
   input  logic signed [WORD_W-1:0]  req_gyro_z,
   input  logic                      req_mag_ok,
   input  logic signed [WORD_W-1:0]  req_mag_x,
   input  logic signed [WORD_W-1:0]  req_mag_y,
   input  logic signed [WORD_W-1:0]  req_mag_z,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [WORD_W-1:0]  rsp_pub_accel_x,
   output logic signed [WORD_W-1:0]  rsp_pub_accel_y,
   output logic signed [WORD_W-1:0]  rsp_pub_accel_z,
   output logic signed [WORD_W-1:0]  rsp_pub_gyro_x,
   output logic signed [WORD_W-1:0]  rsp_pub_gyro_y,
   output logic signed [WORD_W-1:0]  rsp_pub_gyro_z,
   output logic signed [WORD_W-1:0]  rsp_pub_mag_x,
   output logic signed [WORD_W-1:0]  rsp_pub_mag_y,
   output logic signed [WORD_W-1:0]  rsp_pub_mag_z,
   output logic [2:0]                rsp_status,
   output logic [FAIL_W-1:0]         rsp_read_fail_count,
   output logic [FAIL_W-1:0]         rsp_mag_fail_count,

   input  logic                      csr_write,
   input  logic [CSR_A_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   logic [WORD_W-1:0] gyro_ofs_ff [AXES];
   logic [WORD_W-1:0] gyro_ofs_in [AXES];
   logic [CNT_W-1:0]  stuck_limit_ff, stuck_limit_in;
   logic [CNT_W-1:0]  mag_div_ff, mag_div_in;

   logic [WORD_W-1:0] held_mag_ff [AXES];
   logic [WORD_W-1:0] held_mag_in [AXES];
   logic [WORD_W-1:0] pub_mag_ff [AXES];
   logic [WORD_W-1:0] pub_mag_in [AXES];
   logic [WORD_W-1:0] mag_raw [AXES];

   logic [WORD_W-1:0] lane_raw [LANES];
   logic [WORD_W-1:0] lane_ofs [LANES];
   logic [WORD_W-1:0] lane_pub [LANES];
   logic [LANES-1:0]  lane_match;

   ctl_type           ctl;
   status_type        status;

   // take a word whenever the result register is free or being drained
   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   // configuration registers
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         gyro_ofs_in[a] = gyro_ofs_ff[a];
      end
      stuck_limit_in = stuck_limit_ff;
      mag_div_in     = mag_div_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_GYRO_OFS_X: gyro_ofs_in[0] = csr_wdata;
            CSR_GYRO_OFS_Y: gyro_ofs_in[1] = csr_wdata;
            CSR_GYRO_OFS_Z: gyro_ofs_in[2] = csr_wdata;
            CSR_STUCK_LIM:  stuck_limit_in = csr_wdata[CNT_W-1:0];
            CSR_MAG_DIV:    mag_div_in     = csr_wdata[CNT_W-1:0];
            default: begin
               stuck_limit_in = stuck_limit_ff;
            end
         endcase
      end
   end

   // lane inputs: accel lanes pass through, gyro lanes take the offsets
   assign lane_raw[0] = req_accel_x;
   assign lane_raw[1] = req_accel_y;
   assign lane_raw[2] = req_accel_z;
   assign lane_raw[3] = req_gyro_x;
   assign lane_raw[4] = req_gyro_y;
   assign lane_raw[5] = req_gyro_z;

   assign lane_ofs[0] = '0;
   assign lane_ofs[1] = '0;
   assign lane_ofs[2] = '0;
   assign lane_ofs[3] = gyro_ofs_ff[0];
   assign lane_ofs[4] = gyro_ofs_ff[1];
   assign lane_ofs[5] = gyro_ofs_ff[2];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      isc_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .commit   (ctl.commit),
         .raw_word (lane_raw[l]),
         .offset   (lane_ofs[l]),
         .match    (lane_match[l]),
         .pub_word (lane_pub[l])
      );
   end

   isc_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .read_ok         (req_read_ok),
      .mag_ok          (req_mag_ok),
      .lane_match      (lane_match),
      .stuck_limit     (stuck_limit_ff),
      .mag_divider     (mag_div_ff),
      .ctl             (ctl),
      .status          (status),
      .read_fail_count (rsp_read_fail_count),
      .mag_fail_count  (rsp_mag_fail_count)
   );

   // magnetometer: publish the held words, then capture a good fetch
   assign mag_raw[0] = req_mag_x;
   assign mag_raw[1] = req_mag_y;
   assign mag_raw[2] = req_mag_z;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         pub_mag_in[a]  = ctl.commit   ? held_mag_ff[a] : pub_mag_ff[a];
         held_mag_in[a] = ctl.mag_load ? mag_raw[a]     : held_mag_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         stuck_limit_ff <= STUCK_LIMIT_RESET;
         mag_div_ff     <= MAG_DIVIDER_RESET;
         for (int a = 0; a < AXES; a++) begin
            gyro_ofs_ff[a] <= '0;
            held_mag_ff[a] <= '0;
            pub_mag_ff[a]  <= '0;
         end
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         stuck_limit_ff <= stuck_limit_in;
         mag_div_ff     <= mag_div_in;
         for (int a = 0; a < AXES; a++) begin
            gyro_ofs_ff[a] <= gyro_ofs_in[a];
            held_mag_ff[a] <= held_mag_in[a];
            pub_mag_ff[a]  <= pub_mag_in[a];
         end
      end
   end

   // result word
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pub_accel_x = lane_pub[0];
   assign rsp_pub_accel_y = lane_pub[1];
   assign rsp_pub_accel_z = lane_pub[2];
   assign rsp_pub_gyro_x  = lane_pub[3];
   assign rsp_pub_gyro_y  = lane_pub[4];
   assign rsp_pub_gyro_z  = lane_pub[5];
   assign rsp_pub_mag_x   = pub_mag_ff[0];
   assign rsp_pub_mag_y   = pub_mag_ff[1];
   assign rsp_pub_mag_z   = pub_mag_ff[2];
   assign rsp_status      = status;

endmodule

### rtl/isc_checker.sv
// isc_checker: port-level assertions for imu_sample_stuck_check, and the
// bind that attaches them to the top level.
// Depends on isc_pkg.
module isc_checker
   import isc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic signed [WORD_W-1:0] rsp_pub_gyro_x,
   input logic [2:0]               rsp_status,
   input logic [FAIL_W-1:0]        rsp_read_fail_count,
   input logic [FAIL_W-1:0]        rsp_mag_fail_count
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pub_gyro_x)
         && $stable(rsp_status) && $stable(rsp_read_fail_count))
      else $error("stalled result word changed");

   // every accepted sample gives a result on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted sample produced no result");

   // a read or stuck failure is always counted
   a_read_fail_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_READ_FAIL || rsp_status == ST_STUCK)
         |-> rsp_read_fail_count != '0)
      else $error("read failure reported with zero count");

   // a mag fetch failure is always counted
   a_mag_fail_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_MAG_FAIL |-> rsp_mag_fail_count != '0)
      else $error("mag failure reported with zero count");

endmodule

bind imu_sample_stuck_check isc_checker u_isc_checker (.*);

### test/imu_sample_stuck_check_tb.sv
// Testbench for imu_sample_stuck_check: drives sensor sample words, mirrors the
// stuck check, offset subtraction and magnetometer hold, and compares each result.
// Depends on isc_pkg and the imu_sample_stuck_check RTL.
`timescale 1ns / 100ps

module imu_sample_stuck_check_tb;
   import isc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_ITEMS  = 60;

   // one sample word as offered on the request channel
   typedef struct packed {
      logic                         read_ok;
      logic [LANES-1:0][WORD_W-1:0] raw;     // accel x/y/z, then gyro x/y/z
      logic                         mag_ok;
      logic [AXES-1:0][WORD_W-1:0]  mag;
   } sample_word_type;

   // one result word
   typedef struct packed {
      logic [LANES+AXES-1:0][WORD_W-1:0] pub;  // accel, gyro, mag
      status_type                        status;
      logic [FAIL_W-1:0]                 read_fails;
      logic [FAIL_W-1:0]                 mag_fails;
   } pub_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   sample_word_type     req_word  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                csr_write = 1'b0;
   logic [CSR_A_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]    csr_wdata = '0;

   logic signed [WORD_W-1:0] rsp_pub_accel_x, rsp_pub_accel_y, rsp_pub_accel_z;
   logic signed [WORD_W-1:0] rsp_pub_gyro_x, rsp_pub_gyro_y, rsp_pub_gyro_z;
   logic signed [WORD_W-1:0] rsp_pub_mag_x, rsp_pub_mag_y, rsp_pub_mag_z;
   logic [2:0]               rsp_status;
   logic [FAIL_W-1:0]        rsp_read_fail_count, rsp_mag_fail_count;

   // mirror of the block's registers and state
   logic [AXES-1:0][WORD_W-1:0]       gyro_ofs    = '0;
   logic [CNT_W-1:0]                  stuck_lim   = STUCK_LIMIT_RESET;
   logic [CNT_W-1:0]                  mag_div     = MAG_DIVIDER_RESET;
   logic [LANES-1:0][WORD_W-1:0]      last_raw    = '0;
   logic [CNT_W-1:0]                  same_run    = '0;
   logic [AXES-1:0][WORD_W-1:0]       held_mag    = '0;
   logic [LANES+AXES-1:0][WORD_W-1:0] pub_words   = '0;
   logic [CNT_W-1:0]                  mag_tick    = MAG_TICK_RESET;
   logic [FAIL_W-1:0]                 read_fails  = '0;
   logic [FAIL_W-1:0]                 mag_fails   = '0;

   sample_word_type sample_queue[$];
   pub_word_type    expected_pubs[$];
   logic [LANES-1:0][WORD_W-1:0] gen_last = '0;

   int error_count = 0;
   int cycle_count = 0;
   int idle_odds   = 4;     // odds of an idle burst start, one in this many; 0 = none
   int send_gap    = 0;
   int stall_gap   = 0;
   int hold_asks   = 0;
   int holds_done  = 0;
   int hold_left   = 0;

   string pub_names[LANES+AXES] = '{"pub_accel_x", "pub_accel_y", "pub_accel_z",
                                    "pub_gyro_x", "pub_gyro_y", "pub_gyro_z",
                                    "pub_mag_x", "pub_mag_y", "pub_mag_z"};

   imu_sample_stuck_check u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_read_ok         (req_word.read_ok),
      .req_accel_x         (req_word.raw[0]),
      .req_accel_y         (req_word.raw[1]),
      .req_accel_z         (req_word.raw[2]),
      .req_gyro_x          (req_word.raw[3]),
      .req_gyro_y          (req_word.raw[4]),
      .req_gyro_z          (req_word.raw[5]),
      .req_mag_ok          (req_word.mag_ok),
      .req_mag_x           (req_word.mag[0]),
      .req_mag_y           (req_word.mag[1]),
      .req_mag_z           (req_word.mag[2]),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pub_accel_x     (rsp_pub_accel_x),
      .rsp_pub_accel_y     (rsp_pub_accel_y),
      .rsp_pub_accel_z     (rsp_pub_accel_z),
      .rsp_pub_gyro_x      (rsp_pub_gyro_x),
      .rsp_pub_gyro_y      (rsp_pub_gyro_y),
      .rsp_pub_gyro_z      (rsp_pub_gyro_z),
      .rsp_pub_mag_x       (rsp_pub_mag_x),
      .rsp_pub_mag_y       (rsp_pub_mag_y),
      .rsp_pub_mag_z       (rsp_pub_mag_z),
      .rsp_status          (rsp_status),
      .rsp_read_fail_count (rsp_read_fail_count),
      .rsp_mag_fail_count  (rsp_mag_fail_count),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic logic [FAIL_W-1:0] bump_sat(input logic [FAIL_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // advance the mirrored state by one accepted sample and return its result
   function automatic pub_word_type next_pub_word(input sample_word_type s);
      pub_word_type r;
      status_type   st;
      if (!s.read_ok) begin
         read_fails = bump_sat(read_fails);
         st = ST_READ_FAIL;
      end else begin
         if (s.raw == last_raw) begin
            if (same_run != '1)
               same_run = same_run + 1'b1;
         end else begin
            same_run = '0;
         end
         if (same_run >= stuck_lim) begin
            read_fails = bump_sat(read_fails);
            st = ST_STUCK;
         end else begin
            last_raw = s.raw;
            for (int i = 0; i < AXES; i++) begin
               pub_words[i] = s.raw[i];
               pub_words[GYRO_LANE0 + i] = s.raw[GYRO_LANE0 + i] - gyro_ofs[i];
               pub_words[LANES + i] = held_mag[i];
            end
            if (mag_tick != '1)
               mag_tick = mag_tick + 1'b1;
            if (mag_tick >= mag_div) begin
               mag_tick = '0;
               if (s.mag_ok) begin
                  held_mag = s.mag;
                  st = ST_MAG_OK;
               end else begin
                  mag_fails = bump_sat(mag_fails);
                  st = ST_MAG_FAIL;
               end
            end else begin
               st = ST_PUB;
            end
         end
      end
      r.pub        = pub_words;
      r.status     = st;
      r.read_fails = read_fails;
      r.mag_fails  = mag_fails;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] seen_v,
                                  input logic [WORD_W-1:0] want_v);
      error_count++;
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, seen_v, want_v);
   endtask

   // sender: offer queued words, hold a stalled word, idle in bursts
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_pubs.push_back(next_pub_word(sample_queue.pop_front()));
         if (req_valid && req_stall) begin
            offer = 1'b1;
         end else if (send_gap > 0) begin
            send_gap--;
            offer = 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            send_gap = $urandom_range(0, 7);
            offer = 1'b0;
         end else begin
            offer = (sample_queue.size() != 0);
         end
         req_valid <= offer;
         if (offer && !(req_valid && req_stall))
            req_word <= sample_queue[0];
      end
   end

   // receiver stall: long hold-offs on request, otherwise random bursts
   always @(posedge clock) begin
      logic hold;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_asks != holds_done) begin
            holds_done = hold_asks;
            hold_left = 90;
         end
         if (hold_left > 0) begin
            hold_left--;
            hold = 1'b1;
         end else if (stall_gap > 0) begin
            stall_gap--;
            hold = 1'b1;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            stall_gap = $urandom_range(0, 7);
            hold = 1'b1;
         end else begin
            hold = 1'b0;
         end
         rsp_stall <= hold;
      end
   end

   // checker: compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      pub_word_type seen, want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         seen.pub        = {rsp_pub_mag_z, rsp_pub_mag_y, rsp_pub_mag_x,
                            rsp_pub_gyro_z, rsp_pub_gyro_y, rsp_pub_gyro_x,
                            rsp_pub_accel_z, rsp_pub_accel_y, rsp_pub_accel_x};
         seen.status     = status_type'(rsp_status);
         seen.read_fails = rsp_read_fail_count;
         seen.mag_fails  = rsp_mag_fail_count;
         if (expected_pubs.size() == 0) begin
            report_mismatch("result word with nothing expected", seen.read_fails, '0);
         end else begin
            want = expected_pubs.pop_front();
            for (int i = 0; i < LANES + AXES; i++)
               if (seen.pub[i] !== want.pub[i])
                  report_mismatch(pub_names[i], seen.pub[i], want.pub[i]);
            if (seen.status !== want.status)
               report_mismatch("status", WORD_W'(seen.status), WORD_W'(want.status));
            if (seen.read_fails !== want.read_fails)
               report_mismatch("read_fail_count", seen.read_fails, want.read_fails);
            if (seen.mag_fails !== want.mag_fails)
               report_mismatch("mag_fail_count", seen.mag_fails, want.mag_fails);
         end
      end
   end

   // write one register and update the mirror
   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_GYRO_OFS_X: gyro_ofs[0] = val;
         CSR_GYRO_OFS_Y: gyro_ofs[1] = val;
         CSR_GYRO_OFS_Z: gyro_ofs[2] = val;
         CSR_STUCK_LIM:  stuck_lim = val[CNT_W-1:0];
         CSR_MAG_DIV:    mag_div = val[CNT_W-1:0];
         default: ;
      endcase
   endtask

   // limit registers get random upper bits, which the block must drop
   task automatic write_limits(input logic [CNT_W-1:0] lim, input logic [CNT_W-1:0] div);
      write_reg(CSR_STUCK_LIM, {CNT_W'($urandom), lim});
      write_reg(CSR_MAG_DIV, {CNT_W'($urandom), div});
   endtask

   // hold until every queued word is taken and every result has come back
   task automatic wait_idle();
      do @(posedge clock);
      while (sample_queue.size() != 0 || expected_pubs.size() != 0 || req_valid);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   function automatic sample_word_type random_sample();
      sample_word_type s;
      s.read_ok = 1'b1;
      for (int i = 0; i < LANES; i++)
         s.raw[i] = rand_word();
      s.mag_ok = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < AXES; i++)
         s.mag[i] = rand_word();
      return s;
   endfunction

   // accel lanes all a, gyro lanes all g, mag axes all m
   function automatic sample_word_type uniform_sample(input logic rd_ok,
                                                      input logic [WORD_W-1:0] a,
                                                      input logic [WORD_W-1:0] g,
                                                      input logic m_ok,
                                                      input logic [WORD_W-1:0] m);
      sample_word_type s;
      s.read_ok = rd_ok;
      s.raw     = {g, g, g, a, a, a};
      s.mag_ok  = m_ok;
      s.mag     = {m, m, m};
      return s;
   endfunction

   // fresh good words, failed reads, and replayed runs to reach the stuck limit
   task automatic queue_random(input int count);
      sample_word_type s;
      int run;
      for (int n = 0; n < count; n += run) begin
         s = random_sample();
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               run = $urandom_range(1, 9);
               for (int k = 0; k < run; k++) begin
                  s = random_sample();
                  s.raw = gen_last;
                  s.read_ok = ($urandom_range(0, 7) != 0);
                  sample_queue.push_back(s);
               end
            end
            3, 4: begin
               run = 1;
               s.read_ok = 1'b0;
               sample_queue.push_back(s);
            end
            default: begin
               run = 1;
               gen_last = s.raw;
               sample_queue.push_back(s);
            end
         endcase
      end
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("imu_sample_stuck_check_tb: done, errors");
      $finish;
   end

   initial begin
      sample_word_type s, t;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // reset settings: first fetch due at once, extremes, stuck after five
      sample_queue.push_back(uniform_sample(1'b1, 16'h0000, 16'h0000, 1'b1, 16'h8000));
      sample_queue.push_back(uniform_sample(1'b1, 16'h7FFF, 16'h8000, 1'b1, 16'h7FFF));
      sample_queue.push_back(uniform_sample(1'b1, 16'h8000, 16'h7FFF, 1'b0, 16'h0000));
      sample_queue.push_back(uniform_sample(1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF));
      for (int i = 0; i < 6; i++)
         sample_queue.push_back(uniform_sample(1'b1, 16'hFFFF, 16'h0001, 1'b1, 16'h0000));
      // a failed read keeps the identical count, the stuck report persists
      sample_queue.push_back(uniform_sample(1'b0, 16'hFFFF, 16'h0001, 1'b1, 16'h0000));
      sample_queue.push_back(uniform_sample(1'b1, 16'hFFFF, 16'h0001, 1'b1, 16'h0000));
      sample_queue.push_back(uniform_sample(1'b1, 16'h5555, 16'hAAAA, 1'b1, 16'h2468));
      wait_idle();

      // extreme offsets, stuck on the first repeat, fetch on every sample not stuck
      write_reg(CSR_GYRO_OFS_X, 16'h8000);
      write_reg(CSR_GYRO_OFS_Y, 16'h7FFF);
      write_reg(CSR_GYRO_OFS_Z, 16'hFFFF);
      write_limits(8'd1, 8'd1);
      sample_queue.push_back(uniform_sample(1'b1, 16'h5555, 16'hAAAA, 1'b0, 16'h0000));
      sample_queue.push_back(uniform_sample(1'b1, 16'h5555, 16'hAAAA, 1'b1, 16'h0000));
      sample_queue.push_back(uniform_sample(1'b1, 16'hAAAA, 16'h5555, 1'b1, 16'h1357));
      sample_queue.push_back(uniform_sample(1'b1, 16'h0000, 16'h0000, 1'b1, 16'hFFFF));
      wait_idle();

      // random offsets, middling limits, with one long result hold-off
      write_reg(CSR_GYRO_OFS_X, CSR_W'($urandom));
      write_reg(CSR_GYRO_OFS_Y, CSR_W'($urandom));
      write_reg(CSR_GYRO_OFS_Z, CSR_W'($urandom));
      write_limits(8'd3, 8'd4);
      queue_random(80);
      hold_asks++;
      wait_idle();

      // zero limits: every good read stuck, fetch due on every sample
      write_limits(8'd0, 8'd0);
      queue_random(60);
      wait_idle();

      // top limits: a long identical run walks the count into saturation
      write_limits(8'd255, 8'd255);
      s = random_sample();
      gen_last = s.raw;
      for (int i = 0; i < 260; i++) begin
         t = random_sample();
         t.raw = s.raw;
         sample_queue.push_back(t);
      end
      queue_random(40);
      wait_idle();

      // heavy idling on both sides, another hold-off
      write_reg(CSR_GYRO_OFS_X, 16'h7FFF);
      write_reg(CSR_GYRO_OFS_Y, 16'h8000);
      write_reg(CSR_GYRO_OFS_Z, 16'h0001);
      write_limits(8'd2, 8'd7);
      idle_odds = 2;
      queue_random(80);
      hold_asks++;
      wait_idle();

      // no idling: alternate failed reads and failed fetches back to back
      idle_odds = 0;
      write_limits(8'd255, 8'd1);
      for (int i = 0; i < TAIL_ITEMS; i++) begin
         s = random_sample();
         s.read_ok = i[0];
         s.mag_ok = 1'b0;
         sample_queue.push_back(s);
      end
      wait_idle();
      repeat (8) @(posedge clock);

      if (expected_pubs.size() != 0)
         report_mismatch("results never delivered", WORD_W'(expected_pubs.size()), '0);
      if (error_count == 0)
         $display("imu_sample_stuck_check_tb: done, clean");
      else
         $display("imu_sample_stuck_check_tb: done, errors");
      $finish;
   end

endmodule
